### rtl/wrs_pkg.sv
package wrs_pkg;

  // Position and route length never exceed 31: the length register is 5 bits.
  localparam int POS_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int TICK_W  = 32;
  localparam int TOUT_W  = 16;
  localparam int RETRY_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  typedef enum logic [3:0] {
    CMD_LOAD        = 4'd0,
    CMD_ADVANCE     = 4'd1,
    CMD_MARK_RETURN = 4'd2,
    CMD_GOTO_ID     = 4'd3,
    CMD_CANCEL_RET  = 4'd4,
    CMD_SKIP        = 4'd5,
    CMD_CHECK_TOUT  = 4'd6,
    CMD_RETRY       = 4'd7,
    CMD_RESET_TIMER = 4'd8,
    CMD_RESET_RETRY = 4'd9
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUTE_LENGTH = 2'd0,
    REG_LOOP_START   = 2'd1,
    REG_MOVE_TIMEOUT = 2'd2,
    REG_RETRY_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   ret_pos;
    logic               returning;
    logic [RETRY_W-1:0] retry_cnt;
    logic               exceeded;
    logic [TICK_W-1:0]  timer_start;
  } wrs_state_t;

  typedef struct packed {
    logic [POS_W-1:0]   eff_len;
    logic [SLOT_W-1:0]  loop_start;
    logic [TOUT_W-1:0]  timeout;
    logic [RETRY_W-1:0] limit;
  } wrs_cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TICK_W-1:0] now;
    logic              found;
    logic [POS_W-1:0]  found_idx;
  } wrs_ctx_t;

  typedef struct packed {
    wrs_state_t st;
    logic       timed_out;
  } wrs_result_t;

endpackage

### rtl/wrs_if.sv
interface wrs_in_if #(
  parameter int ID_BITS = 8
);
  logic                          valid;
  logic                          ready;
  logic [3:0]                    command;
  logic [wrs_pkg::SLOT_W-1:0]    entry_slot;
  logic [ID_BITS-1:0]            waypoint_id;
  logic [wrs_pkg::TICK_W-1:0]    now_ticks;

  modport source (output valid, command, entry_slot, waypoint_id, now_ticks, input ready);
  modport sink   (input valid, command, entry_slot, waypoint_id, now_ticks, output ready);
endinterface

interface wrs_out_if #(
  parameter int ID_BITS = 8
);
  logic                          valid;
  logic                          ready;
  logic [ID_BITS-1:0]            target_id;
  logic [wrs_pkg::SLOT_W-1:0]    target_slot;
  logic [wrs_pkg::RETRY_W-1:0]   retries;
  logic                          retries_over;
  logic                          return_pending;
  logic                          timed_out;

  modport source (output valid, target_id, target_slot, retries, retries_over,
                  return_pending, timed_out, input ready);
  modport sink   (input valid, target_id, target_slot, retries, retries_over,
                  return_pending, timed_out, output ready);
endinterface

### rtl/wrs_step_unit.sv
module wrs_step_unit (
  input  wrs_pkg::wrs_state_t  cur,
  input  wrs_pkg::wrs_cfg_t    cfg,
  input  wrs_pkg::wrs_ctx_t    ctx,
  output wrs_pkg::wrs_result_t res
);
  import wrs_pkg::*;

  logic [POS_W:0]     pos_inc;
  logic [TICK_W-1:0]  start_eff;
  logic [TICK_W-1:0]  elapsed;
  logic [RETRY_W-1:0] retry_inc;
  wrs_state_t         adv;

  // Advance: go back to the marked position if one is pending, else step and wrap.
  always_comb begin
    pos_inc = {1'b0, cur.pos} + {{POS_W{1'b0}}, 1'b1};
    adv     = cur;
    if (cur.returning) begin
      adv.pos       = cur.ret_pos;
      adv.returning = 1'b0;
      adv.ret_pos   = '0;
    end else begin
      adv.pos = (pos_inc >= {1'b0, cfg.eff_len}) ? POS_W'(cfg.loop_start) : pos_inc[POS_W-1:0];
      adv.retry_cnt   = '0;
      adv.exceeded    = 1'b0;
      adv.timer_start = ctx.now;
    end
  end

  always_comb begin
    start_eff = (cur.timer_start == '0) ? ctx.now : cur.timer_start;
    elapsed   = ctx.now - start_eff;
    retry_inc = (cur.retry_cnt == RETRY_MAX) ? cur.retry_cnt : cur.retry_cnt + 1'b1;

    res.st        = cur;
    res.timed_out = 1'b0;
    case (ctx.cmd)
      CMD_ADVANCE: begin
        res.st = adv;
      end
      CMD_MARK_RETURN: begin
        if (cur.pos != '0) begin
          res.st.ret_pos   = cur.pos - 1'b1;
          res.st.returning = 1'b1;
        end
      end
      CMD_GOTO_ID: begin
        if (ctx.found) begin
          res.st.pos         = ctx.found_idx;
          res.st.retry_cnt   = '0;
          res.st.exceeded    = 1'b0;
          res.st.returning   = 1'b0;
          res.st.ret_pos     = '0;
          res.st.timer_start = ctx.now;
        end
      end
      CMD_CANCEL_RET: begin
        res.st.returning = 1'b0;
        res.st.ret_pos   = '0;
      end
      CMD_SKIP: begin
        res.st           = adv;
        res.st.retry_cnt = '0;
        res.st.exceeded  = 1'b0;
      end
      CMD_CHECK_TOUT: begin
        res.st.timer_start = start_eff;
        res.timed_out      = elapsed > {{(TICK_W-TOUT_W){1'b0}}, cfg.timeout};
      end
      CMD_RETRY: begin
        res.st.retry_cnt   = retry_inc;
        res.st.exceeded    = cur.exceeded | (retry_inc >= cfg.limit);
        res.st.timer_start = ctx.now;
      end
      CMD_RESET_TIMER: begin
        res.st.timer_start = ctx.now;
      end
      CMD_RESET_RETRY: begin
        res.st.retry_cnt = '0;
        res.st.exceeded  = 1'b0;
      end
      default: begin
        res.st = cur;
      end
    endcase
  end

endmodule

### rtl/waypoint_route_sequencer.sv
// Channel   Dir  Transaction                                   Handshake
// in_ch     in   command, entry_slot, waypoint_id, now_ticks    valid/ready
// out_ch    out  target_id, target_slot, retries, flags         valid/ready
// cfg_*     in   register index and write data                  cfg_we, no wait
//
// An event passes accept, execute and table read; goto id first scans the
// route up to the effective route length, one table entry compared per cycle
// through the single read port of the route memory.
// Reset is synchronous, active low; the route memory is not cleared.
// in_ch is ready only while the sequencer is idle and out of reset; a result
// waiting on out_ch does not block the next transaction, only the one after it.
module waypoint_route_sequencer #(
  parameter int ROUTE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wrs_in_if.sink                         in_ch,
  wrs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [wrs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wrs_pkg::*;

  localparam int IDX_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_FETCH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [POS_W-1:0]   route_len_r;
  logic [SLOT_W-1:0]  loop_start_r;
  logic [TOUT_W-1:0]  move_tout_r;
  logic [RETRY_W-1:0] retry_limit_r;

  // Architectural state
  wrs_state_t st_r;

  // Latched transaction
  cmd_t               cmd_r;
  logic [ID_BITS-1:0] id_r;
  logic [TICK_W-1:0]  now_r;

  // Goto-id search
  logic [POS_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [POS_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               found_r, found_nxt;
  logic [POS_W-1:0]   found_idx_r, found_idx_nxt;

  // Route memory
  logic [ID_BITS-1:0] route_mem [ROUTE_DEPTH];
  logic [ID_BITS-1:0] rd_q_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;

  // Result register
  logic               out_valid_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [RETRY_W-1:0] out_retries_r;
  logic               out_over_r;
  logic               out_ret_r;
  logic               out_tout_r;
  logic               timed_out_r;

  logic               in_fire;
  logic               out_load;
  logic [POS_W-1:0]   eff_len;
  logic               scan_hit;
  logic               in_range;

  wrs_cfg_t    cfg;
  wrs_ctx_t    ctx;
  wrs_result_t step_res;

  // Effective length is the smaller of the register and the table depth.
  assign eff_len = (32'(route_len_r) < ROUTE_DEPTH) ? route_len_r : POS_W'(ROUTE_DEPTH);

  // Hold off the input while in reset so no transaction is dropped there.
  assign in_ch.ready = (state_r == S_IDLE) && rst_n;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign cfg.eff_len    = eff_len;
  assign cfg.loop_start = loop_start_r;
  assign cfg.timeout    = move_tout_r;
  assign cfg.limit      = retry_limit_r;

  assign ctx.cmd       = cmd_r;
  assign ctx.now       = now_r;
  assign ctx.found     = found_r;
  assign ctx.found_idx = found_idx_r;

  wrs_step_unit u_step (
    .cur (st_r),
    .cfg (cfg),
    .ctx (ctx),
    .res (step_res)
  );

  // A compare lands in the cycle after its read was issued.
  assign scan_hit = cmp_vld_r && (rd_q_r == id_r);
  assign in_range = st_r.pos < eff_len;

  // Hold the result until taken; load the next one only into a free slot.
  assign out_load = (state_r == S_FETCH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          state_nxt    = (cmd_t'(in_ch.command) == CMD_GOTO_ID) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          found_nxt     = 1'b1;
          found_idx_nxt = cmp_idx_r;
          state_nxt     = S_EXEC;
        end else if (scan_idx_r >= eff_len) begin
          state_nxt = S_EXEC;
        end else begin
          rd_en        = 1'b1;
          rd_addr      = IDX_W'(scan_idx_r);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_EXEC: begin
        // Read the entry at the new position for the report.
        rd_en     = 1'b1;
        rd_addr   = IDX_W'(step_res.st.pos);
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      route_len_r   <= '0;
      loop_start_r  <= '0;
      move_tout_r   <= TOUT_W'(10000);
      retry_limit_r <= RETRY_W'(10);
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (state_r == S_EXEC) begin
        st_r <= step_res.st;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_ROUTE_LENGTH: route_len_r   <= cfg_wdata[POS_W-1:0];
          REG_LOOP_START:   loop_start_r  <= cfg_wdata[SLOT_W-1:0];
          REG_MOVE_TIMEOUT: move_tout_r   <= cfg_wdata[TOUT_W-1:0];
          REG_RETRY_LIMIT:  retry_limit_r <= cfg_wdata[RETRY_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    if (in_fire) begin
      cmd_r <= cmd_t'(in_ch.command);
      id_r  <= in_ch.waypoint_id;
      now_r <= in_ch.now_ticks;
    end
    if (state_r == S_EXEC) begin
      timed_out_r <= step_res.timed_out;
    end
    if (out_load) begin
      out_id_r      <= in_range ? rd_q_r : '0;
      out_slot_r    <= st_r.pos[SLOT_W-1:0];
      out_retries_r <= st_r.retry_cnt;
      out_over_r    <= st_r.exceeded;
      out_ret_r     <= st_r.returning;
      out_tout_r    <= timed_out_r;
    end
  end

  // Route memory: load writes at accept, slots beyond the depth are dropped.
  always_ff @(posedge clk) begin
    if (in_fire && (cmd_t'(in_ch.command) == CMD_LOAD) &&
        (32'(in_ch.entry_slot) < ROUTE_DEPTH)) begin
      route_mem[IDX_W'(in_ch.entry_slot)] <= in_ch.waypoint_id;
    end
    if (rd_en) begin
      rd_q_r <= route_mem[rd_addr];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.target_id      = out_id_r;
  assign out_ch.target_slot    = out_slot_r;
  assign out_ch.retries        = out_retries_r;
  assign out_ch.retries_over   = out_over_r;
  assign out_ch.return_pending = out_ret_r;
  assign out_ch.timed_out      = out_tout_r;

endmodule

### dv/tb_waypoint_route_sequencer.sv
`timescale 1ns / 1ps

module tb_waypoint_route_sequencer;
  import wrs_pkg::*;

  localparam int ROUTE_DEPTH    = 16;
  localparam int ID_BITS        = 8;
  localparam int MAX_GAP        = 18;
  localparam int SETTLE_CYCLES  = 24;    // room for one event plus a full id search
  localparam int HOLD_OFF       = 250;   // long receiver stall for the pressure test
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int MAX_SHOWN      = 10;
  localparam int PHASE_COUNT    = 10;

  // Commands outside the defined set report only.
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [ID_BITS-1:0] target_id;
    logic [SLOT_W-1:0]  target_slot;
    logic [RETRY_W-1:0] retries;
    logic               retries_over;
    logic               return_pending;
    logic               timed_out;
  } route_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wrs_in_if  #(.ID_BITS(ID_BITS)) in_ch ();
  wrs_out_if #(.ID_BITS(ID_BITS)) out_ch ();

  waypoint_route_sequencer #(
    .ROUTE_DEPTH (ROUTE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the sequencer: route table, position, return mark, retries, timer.
  logic [ID_BITS-1:0] route_mem [ROUTE_DEPTH];
  int unsigned        cur_pos;
  int unsigned        ret_pos;
  bit                 ret_armed;
  int unsigned        retry_cnt;
  bit                 retry_hit;
  logic [TICK_W-1:0]  timer_origin;

  // Mirror of the register file.
  logic [POS_W-1:0]   cfg_len;
  logic [SLOT_W-1:0]  cfg_loop;
  logic [TOUT_W-1:0]  cfg_tout;
  logic [RETRY_W-1:0] cfg_limit;

  route_report_t expected_reports [$];

  logic [TICK_W-1:0] tick_clock;
  bit tx_no_idle;
  bit rx_no_idle;
  int rx_hold_cycles;
  int events_sent;
  int reports_checked;
  int cfg_writes;
  int mismatches;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned route_len();
    return (cfg_len < ROUTE_DEPTH) ? int'(cfg_len) : ROUTE_DEPTH;
  endfunction

  // Move forward one point, or jump back when a return is armed.
  function automatic void step_forward(logic [TICK_W-1:0] now);
    if (ret_armed) begin
      cur_pos   = ret_pos;
      ret_armed = 1'b0;
      ret_pos   = 0;
    end else begin
      cur_pos++;
      if (cur_pos >= route_len())
        cur_pos = cfg_loop;
      retry_cnt    = 0;
      retry_hit    = 1'b0;
      timer_origin = now;
    end
  endfunction

  function automatic route_report_t predict_route_report(logic [3:0] cmd,
      logic [SLOT_W-1:0] slot, logic [ID_BITS-1:0] id, logic [TICK_W-1:0] now);
    route_report_t     rep;
    logic [TICK_W-1:0] elapsed;
    bit                late;
    bit                hit;
    int unsigned       i;
    late = 1'b0;
    hit  = 1'b0;
    case (cmd)
      CMD_LOAD:        route_mem[slot] = id;
      CMD_ADVANCE:     step_forward(now);
      CMD_MARK_RETURN: begin
        if (cur_pos > 0) begin
          ret_pos   = cur_pos - 1;
          ret_armed = 1'b1;
        end
      end
      CMD_GOTO_ID: begin
        // First matching slot wins; an absent id leaves everything alone.
        for (i = 0; i < route_len() && !hit; i++) begin
          if (route_mem[i] == id) begin
            hit          = 1'b1;
            cur_pos      = i;
            retry_cnt    = 0;
            retry_hit    = 1'b0;
            ret_armed    = 1'b0;
            ret_pos      = 0;
            timer_origin = now;
          end
        end
      end
      CMD_CANCEL_RET: begin
        ret_armed = 1'b0;
        ret_pos   = 0;
      end
      CMD_SKIP: begin
        retry_cnt = 0;
        retry_hit = 1'b0;
        step_forward(now);
      end
      CMD_CHECK_TOUT: begin
        if (timer_origin == '0)
          timer_origin = now;
        elapsed = now - timer_origin;
        late    = (elapsed > {16'h0000, cfg_tout});
      end
      CMD_RETRY: begin
        if (retry_cnt < 255)
          retry_cnt++;
        if (retry_cnt >= cfg_limit)
          retry_hit = 1'b1;
        timer_origin = now;
      end
      CMD_RESET_TIMER: timer_origin = now;
      CMD_RESET_RETRY: begin
        retry_cnt = 0;
        retry_hit = 1'b0;
      end
      default: ;
    endcase
    rep.target_id      = (cur_pos < route_len()) ? route_mem[cur_pos] : '0;
    rep.target_slot    = SLOT_W'(cur_pos);
    rep.retries        = RETRY_W'(retry_cnt);
    rep.retries_over   = retry_hit;
    rep.return_pending = ret_armed;
    rep.timed_out      = late;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly a creeping clock so elapsed times land near the timeout, with
  // occasional zero and arbitrary values.
  function automatic logic [TICK_W-1:0] next_now();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return '0;
    if (r < 10)
      return $urandom;
    tick_clock = tick_clock + $urandom_range(0, int'(cfg_tout) / 4 + 8);
    return tick_clock;
  endfunction

  // Small ids half the time so that the table holds duplicates.
  function automatic logic [ID_BITS-1:0] pick_waypoint();
    if ($urandom_range(0, 1) == 0)
      return ID_BITS'($urandom_range(0, 7));
    return ID_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return CMD_ADVANCE;
    if (r < 26) return CMD_SKIP;
    if (r < 36) return CMD_MARK_RETURN;
    if (r < 42) return CMD_CANCEL_RET;
    if (r < 56) return CMD_GOTO_ID;
    if (r < 70) return CMD_RETRY;
    if (r < 80) return CMD_CHECK_TOUT;
    if (r < 86) return CMD_RESET_TIMER;
    if (r < 91) return CMD_RESET_RETRY;
    if (r < 97) return CMD_LOAD;
    return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  // Offer one transaction and hold it until accepted. Valid stays high on
  // return so that a back-to-back transaction does not drop it.
  task automatic send_event(input logic [3:0] cmd, input logic [SLOT_W-1:0] slot,
                            input logic [ID_BITS-1:0] id, input logic [TICK_W-1:0] now);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.entry_slot  <= slot;
    in_ch.waypoint_id <= id;
    in_ch.now_ticks   <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_reports.push_back(predict_route_report(cmd, slot, id, now));
    events_sent++;
  endtask

  task automatic send_random_event();
    logic [3:0]         cmd;
    logic [ID_BITS-1:0] id;
    cmd = pick_command();
    id  = pick_waypoint();
    // Aim most jumps at ids that are actually on the route.
    if (cmd == CMD_GOTO_ID && route_len() > 0 && $urandom_range(0, 3) != 0)
      id = route_mem[$urandom_range(0, route_len() - 1)];
    send_event(cmd, SLOT_W'($urandom_range(0, 15)), id, next_now());
  endtask

  // Drop valid, wait for every outstanding report, then let the block settle.
  task automatic wait_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ROUTE_LENGTH: cfg_len   = data[POS_W-1:0];
      REG_LOOP_START:   cfg_loop  = data[SLOT_W-1:0];
      REG_MOVE_TIMEOUT: cfg_tout  = data[TOUT_W-1:0];
      REG_RETRY_LIMIT:  cfg_limit = data[RETRY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic program_route(input logic [POS_W-1:0] len, input logic [SLOT_W-1:0] loop,
                               input logic [TOUT_W-1:0] tout, input logic [RETRY_W-1:0] lim);
    wait_quiet();
    cfg_write(REG_ROUTE_LENGTH, CFG_DATA_W'(len));
    cfg_write(REG_LOOP_START,   CFG_DATA_W'(loop));
    cfg_write(REG_MOVE_TIMEOUT, CFG_DATA_W'(tout));
    cfg_write(REG_RETRY_LIMIT,  CFG_DATA_W'(lim));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Fill the first four slots while the route is still empty, so nothing
  // unwritten is ever read. Extreme ids at both ends.
  task automatic test_route_load();
    send_event(CMD_LOAD, 4'd0, 8'hFF, next_now());
    send_event(CMD_LOAD, 4'd1, 8'h00, next_now());
    send_event(CMD_LOAD, 4'd2, 8'h5A, next_now());
    send_event(CMD_LOAD, 4'd3, 8'hA5, next_now());
    send_event(CMD_UNUSED_HI, 4'hF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // Walk the four-point route past its end so it wraps to the loop start.
  task automatic test_route_walk();
    repeat (4) send_event(CMD_ADVANCE, 4'd0, 8'd0, next_now());
    send_event(CMD_SKIP, 4'd0, 8'd0, next_now());
  endtask

  task automatic test_return_marks();
    send_event(CMD_MARK_RETURN, 4'd0, 8'd0, next_now());
    send_event(CMD_ADVANCE, 4'd0, 8'd0, next_now());
    send_event(CMD_MARK_RETURN, 4'd0, 8'd0, next_now());
    send_event(CMD_CANCEL_RET, 4'd0, 8'd0, next_now());
    send_event(CMD_ADVANCE, 4'd0, 8'd0, next_now());
  endtask

  // Present id, absent id, then back to slot 0 where a return mark is a no-op.
  task automatic test_goto();
    send_event(CMD_GOTO_ID, 4'd0, 8'hA5, next_now());
    send_event(CMD_GOTO_ID, 4'd0, 8'h77, next_now());
    send_event(CMD_GOTO_ID, 4'd0, 8'hFF, next_now());
    send_event(CMD_MARK_RETURN, 4'd0, 8'd0, next_now());
  endtask

  // Timer not started, the exact limit, one past it, and elapsed time
  // across a wrap of the tick counter.
  task automatic test_retry_timer();
    send_event(CMD_RETRY, 4'd0, 8'd0, 32'd100);
    send_event(CMD_RETRY, 4'd0, 8'd0, 32'd200);
    send_event(CMD_RESET_RETRY, 4'd0, 8'd0, 32'd300);
    send_event(CMD_RESET_TIMER, 4'd0, 8'd0, 32'd0);
    send_event(CMD_CHECK_TOUT, 4'd0, 8'd0, 32'd5);
    send_event(CMD_CHECK_TOUT, 4'd0, 8'd0, 32'd10005);
    send_event(CMD_CHECK_TOUT, 4'd0, 8'd0, 32'd10006);
    send_event(CMD_RESET_TIMER, 4'd0, 8'd0, 32'hFFFF_FFF0);
    send_event(CMD_CHECK_TOUT, 4'd0, 8'd0, 32'h0000_2800);
  endtask

  // A zero limit trips on the first retry; a limit of 255 trips only at
  // saturation, and the count must stick there.
  task automatic test_retry_saturation();
    program_route(5'd4, 4'd1, 16'd10000, 8'd0);
    send_event(CMD_RETRY, 4'd0, 8'd0, next_now());
    send_event(CMD_RESET_RETRY, 4'd0, 8'd0, next_now());
    program_route(5'd4, 4'd1, 16'd10000, 8'd255);
    tx_no_idle = ($urandom_range(0, 1) == 0);
    repeat (258) send_event(CMD_RETRY, 4'($urandom_range(0, 15)), pick_waypoint(), next_now());
    send_event(CMD_CHECK_TOUT, 4'd0, 8'd0, next_now());
    send_event(CMD_SKIP, 4'd0, 8'd0, next_now());
    tx_no_idle = 1'b0;
  endtask

  // Stall the receiver for a long stretch while transactions keep coming, so
  // the block fills and holds off its input; then pause until all drain.
  task automatic test_backpressure();
    tx_no_idle     = 1'b1;
    rx_hold_cycles = HOLD_OFF;
    repeat (12) send_random_event();
    wait_quiet();
    repeat (6) send_random_event();
    tx_no_idle = 1'b0;
  endtask

  task automatic test_random_routes();
    int                 phase;
    int                 k;
    logic [POS_W-1:0]   len;
    logic [SLOT_W-1:0]  loop;
    logic [TOUT_W-1:0]  tout;
    logic [RETRY_W-1:0] lim;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin len = 5'd16; loop = 4'd15; tout = 16'hFFFF; lim = 8'd255; end
        1: begin len = 5'd0;  loop = 4'd0;  tout = 16'd0;    lim = 8'd0;   end
        2: begin len = 5'd15; loop = 4'd0;  tout = 16'd40;   lim = 8'd1;   end
        default: begin
          len  = ($urandom_range(0, 2) == 0) ? POS_W'($urandom_range(1, 3))
                                             : POS_W'($urandom_range(0, 16));
          loop = SLOT_W'($urandom_range(0, 15));
          tout = ($urandom_range(0, 1) == 0) ? TOUT_W'($urandom_range(0, 500))
                                             : TOUT_W'($urandom_range(0, 65535));
          lim  = RETRY_W'($urandom_range(0, 6));
        end
      endcase
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      tick_clock = ($urandom_range(0, 2) == 0) ? 32'hFFFF_F000 : $urandom;
      // Load the route under the old length, then make it live.
      for (k = 0; k < len; k++)
        send_event(CMD_LOAD, SLOT_W'(k), pick_waypoint(), next_now());
      program_route(len, loop, tout, lim);
      repeat (15 + $urandom_range(0, 10)) send_random_event();
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, or one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Report checker: every result against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : report_check
    route_report_t got;
    route_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{target_id: out_ch.target_id, target_slot: out_ch.target_slot,
              retries: out_ch.retries, retries_over: out_ch.retries_over,
              return_pending: out_ch.return_pending, timed_out: out_ch.timed_out};
      reports_checked++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: report with nothing expected: id=%02h slot=%0d", $realtime,
                   got.target_id, got.target_slot);
      end else begin
        want = expected_reports.pop_front();
        if (got.target_id !== want.target_id || got.target_slot !== want.target_slot ||
            got.retries !== want.retries || got.retries_over !== want.retries_over ||
            got.return_pending !== want.return_pending ||
            got.timed_out !== want.timed_out) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: report %0d mismatch", $realtime, reports_checked);
            $display("  exp id=%02h slot=%0d retries=%0d over=%b ret=%b tout=%b",
                     want.target_id, want.target_slot, want.retries, want.retries_over,
                     want.return_pending, want.timed_out);
            $display("  got id=%02h slot=%0d retries=%0d over=%b ret=%b tout=%b",
                     got.target_id, got.target_slot, got.retries, got.retries_over,
                     got.return_pending, got.timed_out);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no transaction moves for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d reports outstanding",
             WATCHDOG_LIMIT, expected_reports.size());
    $display("** waypoint_route_sequencer: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value from time zero.
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_ROUTE_LENGTH;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_LOAD;
    in_ch.entry_slot  = '0;
    in_ch.waypoint_id = '0;
    in_ch.now_ticks   = '0;
    out_ch.ready      = 1'b0;

    // Reset values of the mirror.
    foreach (route_mem[i]) route_mem[i] = '0;
    cur_pos         = 0;
    ret_pos         = 0;
    ret_armed       = 1'b0;
    retry_cnt       = 0;
    retry_hit       = 1'b0;
    timer_origin    = '0;
    cfg_len         = '0;
    cfg_loop        = '0;
    cfg_tout        = 16'd10000;
    cfg_limit       = 8'd10;
    tick_clock      = 32'd1000;
    tx_no_idle      = 1'b0;
    rx_no_idle      = 1'b0;
    rx_hold_cycles  = 0;
    events_sent     = 0;
    reports_checked = 0;
    cfg_writes      = 0;
    mismatches      = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_route_load();
    program_route(5'd4, 4'd1, 16'd10000, 8'd10);
    test_route_walk();
    test_return_marks();
    test_goto();
    test_retry_timer();
    test_retry_saturation();
    test_backpressure();
    test_random_routes();
    wait_quiet();

    $display("Covered: %0d events (directed commands, retry saturation, stalled output,",
             events_sent);
    $display("  %0d random route settings), %0d reports checked, %0d register writes",
             PHASE_COUNT, reports_checked, cfg_writes);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("** waypoint_route_sequencer: PASSED **");
    end else begin
      $display("%0d mismatches, %0d reports missing", mismatches, expected_reports.size());
      $display("** waypoint_route_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
